// File: design/dsa_pkg.sv
// Shared types, constants and helpers for the descriptor slot allocator.
// Holds the channel word structs, command/status codes and memory request bundles.
// Used by dsa_occ, dsa_hmem and descriptor_slot_allocator_top.
package dsa_pkg;

  localparam int TABLE_SLOTS   = 1024;
  localparam int GROWTH_LIMIT  = 256;
  localparam int INITIAL_SLOTS = 16;
  localparam int HANDLE_WIDTH  = 32;

  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int CAP_W     = SLOT_W + 1;
  localparam int IDX_W     = 11;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int NWORDS    = TABLE_SLOTS / WORD_BITS;
  localparam int WADDR_W   = $clog2(NWORDS);

  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(TABLE_SLOTS);
  localparam logic [CAP_W-1:0] CAP_INIT  =
    (INITIAL_SLOTS > TABLE_SLOTS) ? CAP_W'(TABLE_SLOTS) : CAP_W'(INITIAL_SLOTS);
  localparam logic [CAP_W:0]   CAP_LIMIT = (CAP_W + 1)'(GROWTH_LIMIT);
  localparam logic [CAP_W:0]   DBL_MAX   = (CAP_W + 1)'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W:0]   IDX_DBL_MAX = (IDX_W + 1)'(TABLE_SLOTS);

  typedef logic [HANDLE_WIDTH-1:0] handle_t;

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_ALLOC_FROM = 2'd1,
    CMD_PLACE      = 2'd2,
    CMD_LOOKUP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADF    = 2'd3
  } st_e;

  typedef struct packed {
    cmd_e        command;
    logic [10:0] slot_index;
    logic [31:0] handle_in;
  } in_word_t;

  typedef struct packed {
    st_e         status;
    logic [9:0]  slot_out;
    logic [31:0] handle_out;
    logic        closed_valid;
    logic [31:0] closed_handle;
  } out_word_t;

  // occupancy bitmap port bundle
  typedef struct packed {
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } occ_req_t;

  // handle memory port bundle
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    handle_t           wr_data;
  } hmem_req_t;

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [WADDR_W-1:0] lowest_word(input logic [NWORDS-1:0] v);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WADDR_W'(i);
    end
    return r;
  endfunction

endpackage

// File: design/dsa_occ.sv
// Occupancy bitmap: one bit per slot, packed into words in a synchronous memory.
// Keeps per-word written flags and a per-word full summary in flops.
// Depends on dsa_pkg.
module dsa_occ (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dsa_pkg::occ_req_t                    req,
  output logic [dsa_pkg::WORD_BITS-1:0]        rd_data,
  output logic [dsa_pkg::NWORDS-1:0]           word_full
);

  logic [dsa_pkg::WORD_BITS-1:0] words_r [dsa_pkg::NWORDS];
  logic [dsa_pkg::WORD_BITS-1:0] rdata_r;
  logic [dsa_pkg::NWORDS-1:0]    wvld_r;
  logic [dsa_pkg::NWORDS-1:0]    full_r;
  logic                          rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      words_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= words_r[req.rd_addr];
    end
  end

  // a word never written reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      full_r <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        wvld_r[req.wr_addr] <= 1'b1;
        full_r[req.wr_addr] <= &req.wr_data;
      end
      if (req.rd_en) begin
        rvld_r <= wvld_r[req.rd_addr];
      end
    end
  end

  assign rd_data   = rvld_r ? rdata_r : '0;
  assign word_full = full_r;

endmodule

// File: design/dsa_hmem.sv
// Handle store: one handle per slot in a synchronous memory, registered read.
// Entries carry no reset; the occupancy bitmap says which are live.
// Depends on dsa_pkg.
module dsa_hmem (
  input  logic               clk,
  input  dsa_pkg::hmem_req_t req,
  output dsa_pkg::handle_t   rd_data
);

  dsa_pkg::handle_t handles_r [dsa_pkg::TABLE_SLOTS];
  dsa_pkg::handle_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      handles_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= handles_r[req.rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule

// File: design/descriptor_slot_allocator_top.sv
// Descriptor slot allocator: command sequencer around the occupancy bitmap and
// handle memory. Depends on dsa_pkg, dsa_occ and dsa_hmem.
//
// Usage:
//   in_valid/in_ready/in_data carry one command word (allocate lowest, allocate
//   from start, place exact, lookup). out_valid/out_ready/out_data return one
//   result word per command, in order.
//   One command is in flight at a time. An argument rejected at decode goes
//   straight to the result; lookup and place exact pass through read and
//   modify; an allocate searches with one or two bitmap word reads, then takes
//   a slot through read and modify, or ends full without them.
//   The run time is set by the read-modify-write on the registered-read
//   bitmap and handle memories: read, then modify and write back.
//   The next command is taken in the cycle after the result is moved into the
//   output register, even while that result still waits for out_ready.
//   A receiver stall holds out_data; a second result waits in the sequencer
//   until the output register frees up, and in_ready stays low meanwhile.
//   Reset empties every slot (bitmap summary flags clear at once, no sweep)
//   and sets the capacity to its initial value; the block is ready on the
//   first cycle after reset.
module descriptor_slot_allocator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dsa_pkg::out_word_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_SCAN1 = 7'b0000100,
    S_SCAN2 = 7'b0001000,
    S_RD    = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam int SLOT_W  = dsa_pkg::SLOT_W;
  localparam int CAP_W   = dsa_pkg::CAP_W;
  localparam int IDX_W   = dsa_pkg::IDX_W;
  localparam int BIT_W   = dsa_pkg::BIT_W;
  localparam int WBITS   = dsa_pkg::WORD_BITS;
  localparam int NWORDS  = dsa_pkg::NWORDS;
  localparam int WADDR_W = dsa_pkg::WADDR_W;

  state_t state_r, state_nxt;
  dsa_pkg::cmd_e    cmd_r, cmd_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  dsa_pkg::handle_t h_r, h_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [SLOT_W-1:0] sstart_r, sstart_nxt;
  logic [WADDR_W-1:0] wsel_r, wsel_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  dsa_pkg::st_e     stat_r, stat_nxt;
  dsa_pkg::handle_t hout_r, hout_nxt;
  logic             cv_r, cv_nxt;
  dsa_pkg::handle_t ch_r, ch_nxt;

  dsa_pkg::out_word_t out_r;
  logic               out_valid_r;
  logic               out_load;

  dsa_pkg::occ_req_t  occ_req;
  dsa_pkg::hmem_req_t hmem_req;
  logic [WBITS-1:0]   occ_rd_data;
  logic [NWORDS-1:0]  occ_full;
  dsa_pkg::handle_t   hmem_rd_data;

  // search and growth helpers
  logic [WBITS-1:0]   off_mask;
  logic [WBITS-1:0]   free_bits;
  logic [WADDR_W-1:0] word_base;
  logic               found;
  logic [SLOT_W-1:0]  fslot;
  logic               fslot_ok;
  logic [NWORDS-1:0]  cand;
  logic [IDX_W:0]     dbl_idx;
  logic [CAP_W-1:0]   grow_size;
  logic               idx_ge_cap;
  logic               grow_ok;
  logic [CAP_W-1:0]   grown_cap;
  logic [CAP_W:0]     dbl_cap;
  logic               resolve;
  logic               cur_bit;
  dsa_pkg::handle_t   cur_h;
  logic [WBITS-1:0]   new_word;

  dsa_occ u_occ (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (occ_req),
    .rd_data   (occ_rd_data),
    .word_full (occ_full)
  );

  dsa_hmem u_hmem (
    .clk     (clk),
    .req     (hmem_req),
    .rd_data (hmem_rd_data)
  );

  always_comb begin
    off_mask  = (state_r == S_SCAN1) ? ({WBITS{1'b1}} << sstart_r[BIT_W-1:0])
                                     : {WBITS{1'b1}};
    free_bits = ~occ_rd_data & off_mask;
    word_base = (state_r == S_SCAN1) ? sstart_r[SLOT_W-1:BIT_W] : wsel_r;
    found     = |free_bits;
    fslot     = {word_base, dsa_pkg::lowest_bit(free_bits)};
    fslot_ok  = found && ({1'b0, fslot} < cap_r);
    // words above the start word that still have a free slot
    cand      = ~occ_full & (({NWORDS{1'b1}} << sstart_r[SLOT_W-1:BIT_W]) << 1);

    dbl_idx    = {idx_r, 1'b0};
    grow_size  = (dbl_idx > dsa_pkg::IDX_DBL_MAX) ? dsa_pkg::CAP_MAX
                                                  : dbl_idx[CAP_W-1:0];
    idx_ge_cap = ({1'b0, idx_r} >= (IDX_W + 1)'(cap_r));
    grow_ok    = (grow_size <= cap_r) || (cap_r < dsa_pkg::CAP_MAX);
    grown_cap  = (grow_size > cap_r) ? grow_size : cap_r;
    dbl_cap    = {cap_r, 1'b0};

    cur_bit  = occ_rd_data[slot_r[BIT_W-1:0]];
    cur_h    = cur_bit ? hmem_rd_data : '0;
    new_word = occ_rd_data;
    new_word[slot_r[BIT_W-1:0]] = (h_r != '0);
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    h_nxt      = h_r;
    cap_nxt    = cap_r;
    sstart_nxt = sstart_r;
    wsel_nxt   = wsel_r;
    slot_nxt   = slot_r;
    stat_nxt   = stat_r;
    hout_nxt   = hout_r;
    cv_nxt     = cv_r;
    ch_nxt     = ch_r;
    occ_req    = '0;
    hmem_req   = '0;
    out_load   = 1'b0;
    resolve    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          idx_nxt   = in_data.slot_index;
          h_nxt     = in_data.handle_in[dsa_pkg::HANDLE_WIDTH-1:0];
          stat_nxt  = dsa_pkg::ST_OK;
          hout_nxt  = '0;
          cv_nxt    = 1'b0;
          ch_nxt    = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (cmd_r)
          dsa_pkg::CMD_ALLOC: begin
            if (h_r == '0) begin
              stat_nxt  = dsa_pkg::ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              sstart_nxt      = '0;
              occ_req.rd_en   = 1'b1;
              occ_req.rd_addr = '0;
              state_nxt       = S_SCAN1;
            end
          end
          dsa_pkg::CMD_ALLOC_FROM: begin
            if (idx_r >= dsa_pkg::IDX_LAST) begin
              stat_nxt  = dsa_pkg::ST_INVALID;
              state_nxt = S_DONE;
            end else if (idx_ge_cap && !grow_ok) begin
              stat_nxt  = dsa_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              if (idx_ge_cap) cap_nxt = grown_cap;
              sstart_nxt      = idx_r[SLOT_W-1:0];
              occ_req.rd_en   = 1'b1;
              occ_req.rd_addr = idx_r[SLOT_W-1:BIT_W];
              state_nxt       = S_SCAN1;
            end
          end
          dsa_pkg::CMD_PLACE: begin
            if ({1'b0, idx_r} >= (IDX_W + 1)'(dsa_pkg::TABLE_SLOTS)) begin
              stat_nxt  = dsa_pkg::ST_INVALID;
              state_nxt = S_DONE;
            end else if (idx_ge_cap && !grow_ok) begin
              stat_nxt  = dsa_pkg::ST_FULL;
              state_nxt = S_DONE;
            end else begin
              if (idx_ge_cap) cap_nxt = grown_cap;
              slot_nxt  = idx_r[SLOT_W-1:0];
              state_nxt = S_RD;
            end
          end
          dsa_pkg::CMD_LOOKUP: begin
            // capacity never exceeds the table, so this covers out-of-table too
            if (idx_ge_cap) begin
              stat_nxt  = dsa_pkg::ST_BADF;
              state_nxt = S_DONE;
            end else begin
              slot_nxt  = idx_r[SLOT_W-1:0];
              state_nxt = S_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN1: begin
        if (!found && (|cand)) begin
          wsel_nxt        = dsa_pkg::lowest_word(cand);
          occ_req.rd_en   = 1'b1;
          occ_req.rd_addr = dsa_pkg::lowest_word(cand);
          state_nxt       = S_SCAN2;
        end else begin
          resolve = 1'b1;
        end
      end
      S_SCAN2: begin
        resolve = 1'b1;
      end
      S_RD: begin
        occ_req.rd_en    = 1'b1;
        occ_req.rd_addr  = slot_r[SLOT_W-1:BIT_W];
        hmem_req.rd_en   = 1'b1;
        hmem_req.rd_addr = slot_r;
        state_nxt        = S_MOD;
      end
      S_MOD: begin
        if (cmd_r == dsa_pkg::CMD_LOOKUP) begin
          if (!cur_bit) stat_nxt = dsa_pkg::ST_BADF;
          else          hout_nxt = cur_h;
        end else begin
          if (cmd_r == dsa_pkg::CMD_PLACE) begin
            cv_nxt = cur_bit;
            ch_nxt = cur_h;
          end
          hmem_req.wr_en   = 1'b1;
          hmem_req.wr_addr = slot_r;
          hmem_req.wr_data = h_r;
          occ_req.wr_en    = 1'b1;
          occ_req.wr_addr  = slot_r[SLOT_W-1:BIT_W];
          occ_req.wr_data  = new_word;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // search finished: take the slot, grow by doubling for allocate lowest, or report full
    if (resolve) begin
      priority if (fslot_ok) begin
        slot_nxt  = fslot;
        state_nxt = S_RD;
      end else if (cmd_r == dsa_pkg::CMD_ALLOC && {1'b0, cap_r} < dsa_pkg::CAP_LIMIT &&
                   dbl_cap <= dsa_pkg::DBL_MAX) begin
        cap_nxt   = dbl_cap[CAP_W-1:0];
        slot_nxt  = cap_r[SLOT_W-1:0];
        state_nxt = S_RD;
      end else begin
        stat_nxt  = dsa_pkg::ST_FULL;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= dsa_pkg::CAP_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    h_r      <= h_nxt;
    sstart_r <= sstart_nxt;
    wsel_r   <= wsel_nxt;
    slot_r   <= slot_nxt;
    stat_r   <= stat_nxt;
    hout_r   <= hout_nxt;
    cv_r     <= cv_nxt;
    ch_r     <= ch_nxt;
    if (out_load) begin
      out_r.status        <= stat_r;
      out_r.slot_out      <= (stat_r == dsa_pkg::ST_OK) ? slot_r : '0;
      out_r.handle_out    <= hout_r;
      out_r.closed_valid  <= cv_r;
      out_r.closed_handle <= ch_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a pending result must not overwrite a word the receiver has not taken
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result left the sequencer while the output word was stalled");

  a_cap_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cap_r >= $past(cap_r)))
    else $error("capacity shrank");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= dsa_pkg::CAP_MAX))
    else $error("capacity out of range");

  a_mod_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> ({1'b0, slot_r} < cap_r))
    else $error("memory update outside active capacity");

  a_err_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != dsa_pkg::ST_OK) |-> (out_r.slot_out == '0))
    else $error("error result carries a slot index");

endmodule
